FILE: sv/lupg_pkg.sv
// lupg_pkg: shared widths, codes and types for the lehmer uniform path generator
// no dependencies; compiled first, used by the channel interfaces and the top level
package lupg_pkg;

	localparam int MAX_DIMENSION = 64;
	localparam int ADDR_W        = $clog2(MAX_DIMENSION);
	localparam int LEN_W         = $clog2(MAX_DIMENSION + 1);
	localparam int GEN_W         = 31;
	localparam int MULT_W        = 15;
	localparam int COUNT_W       = 16;
	localparam int OPCODE_W      = 2;
	localparam int REG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 31;
	localparam int PROD_W        = 2 * GEN_W;
	localparam int K_W           = COUNT_W + 1 + LEN_W;

	localparam logic [MULT_W-1:0] LCG_MULT = MULT_W'(16807);
	localparam logic [GEN_W-1:0]  LCG_MOD  = {GEN_W{1'b1}};

	typedef enum logic [OPCODE_W-1:0] {
		OP_DRAW    = 2'd0,
		OP_SKIP    = 2'd1,
		OP_RESTART = 2'd2
	} opcode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_SEED  = 2'd0,
		REG_PATH_LENGTH = 2'd1,
		REG_ANTITHETIC  = 2'd2
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FRESH_MUL,
		ST_FRESH_RED,
		ST_MIRROR_READ,
		ST_MIRROR_OUT,
		ST_JUMP_GEN_MUL,
		ST_JUMP_GEN_RED,
		ST_JUMP_BASE_MUL,
		ST_JUMP_BASE_RED
	} state_t;

endpackage

FILE: sv/lupg_req_if.sv
// lupg_req_if: request channel of the path generator (opcode and skip count)
// depends on lupg_pkg for field widths
interface lupg_req_if
	import lupg_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [COUNT_W-1:0]  path_count;

	modport source (output valid, output opcode, output path_count, input ready);
	modport sink   (input valid, input opcode, input path_count, output ready);
endinterface

FILE: sv/lupg_res_if.sv
// lupg_res_if: result channel of the path generator, one uniform per transfer
// depends on lupg_pkg for field widths
interface lupg_res_if
	import lupg_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [GEN_W-1:0]  uniform_fraction;
	logic [ADDR_W-1:0] coordinate_index;
	logic              last_in_path;

	modport source (output valid, output uniform_fraction, output coordinate_index,
		output last_in_path, input ready);
	modport sink   (input valid, input uniform_fraction, input coordinate_index,
		input last_in_path, output ready);
endinterface

FILE: sv/lehmer_uniform_path_generator.sv
// lehmer_uniform_path_generator: park-miller generator with antithetic path mirroring
// depends on lupg_pkg, lupg_req_if and lupg_res_if
//
// usage:
//   req channel takes one request at a time: draw a path, skip path_count paths, or
//   restart from start_seed. res channel returns one uniform per transfer, Q0.31,
//   with its coordinate index and a last flag on the final uniform of the path.
//   configuration is written through write_enable / register_index / write_data;
//   the user must write it only while the block is idle, which the block does not
//   enforce. a write to path length or antithetic mode makes the next path fresh.
// steps:
//   a fresh path makes each uniform by the 31x15 multiply, then the mod 2^31-1
//   fold. a mirrored path makes each uniform by a mirror store read, then the
//   complement. a skip runs square-and-multiply over the bits of the number of
//   fresh steps to skip (skipped fresh paths times effective length) through the
//   same shared modular multiplier, over at most 22 bits; when it ends between a
//   fresh path and its mirror, it then draws that fresh path without output,
//   refilled into the store. restart reloads the generator from start_seed.
//   the next request is taken once the previous one ends.
// reset: generator value 1, fresh phase, registers at their defaults; the mirror
//   store holds nothing useful until a fresh path is drawn.
// stalls: the result register holds while res.ready is low and generation waits.
module lehmer_uniform_path_generator
	import lupg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  write_enable,
	input  logic [REG_IDX_W-1:0]  register_index,
	input  logic [CFG_DATA_W-1:0] write_data,
	lupg_req_if.sink              req,
	lupg_res_if.source            res
);

	// configuration
	logic [GEN_W-1:0] seed_q;
	logic [LEN_W-1:0] plen_q;
	logic             anti_q;

	// control and datapath state
	state_t           state_q, state_d;
	logic [GEN_W-1:0] gen_q;
	logic [GEN_W-1:0] base_q;
	logic [K_W-1:0]   k_q;
	logic [LEN_W-1:0] idx_q;
	logic             emit_q;
	logic             fill_q;
	logic             mp_q;
	logic [PROD_W-1:0] prod_s1;
	logic [GEN_W-1:0] rd_s1;

	logic [GEN_W-1:0] store_mem [MAX_DIMENSION];

	logic             out_valid_q;
	logic [GEN_W-1:0] out_frac_q;
	logic [ADDR_W-1:0] out_idx_q;
	logic             out_last_q;

	// combinational
	logic [LEN_W-1:0] len;
	logic             is_last;
	logic             out_free;
	logic             req_take;
	logic             mirror_draw;
	logic [GEN_W-1:0] mul_a;
	logic [GEN_W-1:0] mul_b;
	logic [GEN_W:0]   fold_sum;
	logic [GEN_W-1:0] red;
	logic [COUNT_W:0] fresh_paths;
	logic             end_pending;
	logic [COUNT_W:0] jump_paths;
	logic [K_W-1:0]   jump_steps;
	logic [GEN_W-1:0] seed_fixed;
	logic             fresh_adv;
	logic             mirror_adv;
	logic [GEN_W-1:0] mirror_val;

	// effective length: zero acts as one, longer than the store acts as full
	always_comb begin
		if (plen_q == '0) begin
			len = LEN_W'(1);
		end else if (plen_q > LEN_W'(MAX_DIMENSION)) begin
			len = LEN_W'(MAX_DIMENSION);
		end else begin
			len = plen_q;
		end
	end

	assign is_last     = (idx_q + LEN_W'(1)) == len;
	assign out_free    = !out_valid_q || res.ready;
	assign req_take    = req.valid && req.ready;
	assign mirror_draw = anti_q && mp_q;
	assign mirror_val  = (~rd_s1) + GEN_W'(1);

	// 2^31 = 1 mod 2^31-1, so the product folds to high + low with one correction
	assign fold_sum = {1'b0, prod_s1[PROD_W-1:GEN_W]} + {1'b0, prod_s1[GEN_W-1:0]};
	assign red      = (fold_sum >= {1'b0, LCG_MOD}) ? GEN_W'(fold_sum - {1'b0, LCG_MOD})
		: fold_sum[GEN_W-1:0];

	// the fresh product is recomputed while the fold waits on a stalled result
	assign mul_a = (state_q == ST_JUMP_BASE_MUL) ? base_q : gen_q;
	assign mul_b = (state_q == ST_FRESH_MUL || state_q == ST_FRESH_RED) ? GEN_W'(LCG_MULT)
		: base_q;

	// skip bookkeeping in antithetic mode: count fresh paths, keep the last one if
	// the skip ends between a fresh path and its mirror
	assign fresh_paths = mp_q ? ({1'b0, req.path_count} >> 1)
		: (({1'b0, req.path_count} + (COUNT_W+1)'(1)) >> 1);
	assign end_pending = mp_q ^ req.path_count[0];
	always_comb begin
		if (!anti_q) begin
			jump_paths = {1'b0, req.path_count};
		end else if (end_pending) begin
			jump_paths = fresh_paths - (COUNT_W+1)'(1);
		end else begin
			jump_paths = fresh_paths;
		end
	end
	assign jump_steps = K_W'(jump_paths * len);

	assign seed_fixed = (seed_q == '0 || seed_q == LCG_MOD) ? GEN_W'(1) : seed_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.opcode)
						OP_DRAW: state_d = mirror_draw ? ST_MIRROR_READ : ST_FRESH_MUL;
						OP_SKIP: state_d = (req.path_count != '0) ? ST_JUMP_GEN_MUL : ST_IDLE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FRESH_MUL: state_d = ST_FRESH_RED;
			ST_FRESH_RED: begin
				if (out_free || !emit_q) begin
					state_d = is_last ? ST_IDLE : ST_FRESH_MUL;
				end
			end
			ST_MIRROR_READ: state_d = ST_MIRROR_OUT;
			ST_MIRROR_OUT: begin
				if (out_free) begin
					state_d = is_last ? ST_IDLE : ST_MIRROR_READ;
				end
			end
			ST_JUMP_GEN_MUL: begin
				if (k_q == '0) begin
					state_d = fill_q ? ST_FRESH_MUL : ST_IDLE;
				end else if (k_q[0]) begin
					state_d = ST_JUMP_GEN_RED;
				end else begin
					state_d = ST_JUMP_BASE_MUL;
				end
			end
			ST_JUMP_GEN_RED:  state_d = ST_JUMP_BASE_MUL;
			ST_JUMP_BASE_MUL: state_d = ST_JUMP_BASE_RED;
			ST_JUMP_BASE_RED: state_d = ST_JUMP_GEN_MUL;
			default:          state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready  = 1'b0;
		fresh_adv  = 1'b0;
		mirror_adv = 1'b0;
		unique case (state_q)
			ST_IDLE:       req.ready  = 1'b1;
			ST_FRESH_RED:  fresh_adv  = out_free || !emit_q;
			ST_MIRROR_OUT: mirror_adv = out_free;
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seed_q  <= GEN_W'(1);
			plen_q  <= LEN_W'(1);
			anti_q  <= 1'b0;
			gen_q   <= GEN_W'(1);
			base_q  <= GEN_W'(LCG_MULT);
			k_q     <= '0;
			idx_q   <= '0;
			emit_q  <= 1'b0;
			fill_q  <= 1'b0;
			mp_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (write_enable) begin
				unique case (register_index)
					REG_START_SEED: seed_q <= write_data[GEN_W-1:0];
					REG_PATH_LENGTH: begin
						plen_q <= write_data[LEN_W-1:0];
						mp_q   <= 1'b0;
					end
					REG_ANTITHETIC: begin
						anti_q <= write_data[0];
						mp_q   <= 1'b0;
					end
					default: ;
				endcase
			end

			if (req_take) begin
				case (req.opcode)
					OP_DRAW: begin
						idx_q  <= '0;
						emit_q <= 1'b1;
						mp_q   <= anti_q && !mirror_draw;
					end
					OP_SKIP: begin
						if (req.path_count != '0) begin
							base_q <= GEN_W'(LCG_MULT);
							k_q    <= jump_steps;
							idx_q  <= '0;
							emit_q <= 1'b0;
							fill_q <= anti_q && end_pending;
							mp_q   <= anti_q && end_pending;
						end
					end
					OP_RESTART: begin
						gen_q <= seed_fixed;
						mp_q  <= 1'b0;
					end
					default: ;
				endcase
			end

			if (fresh_adv) begin
				gen_q <= red;
				idx_q <= idx_q + LEN_W'(1);
			end
			if (mirror_adv) begin
				idx_q <= idx_q + LEN_W'(1);
			end
			if (state_q == ST_JUMP_GEN_RED) begin
				gen_q <= red;
			end
			if (state_q == ST_JUMP_BASE_RED) begin
				base_q <= red;
				k_q    <= k_q >> 1;
			end
		end
	end

	// shared modular multiplier, product registered before the fold
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// mirror store: fresh values written as they are made, read into a register ahead of use
	always_ff @(posedge clk) begin
		if (fresh_adv) begin
			store_mem[idx_q[ADDR_W-1:0]] <= red;
		end
		rd_s1 <= store_mem[idx_q[ADDR_W-1:0]];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((fresh_adv && emit_q) || mirror_adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((fresh_adv && emit_q) || mirror_adv) begin
			out_frac_q <= mirror_adv ? mirror_val : red;
			out_idx_q  <= idx_q[ADDR_W-1:0];
			out_last_q <= is_last;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.uniform_fraction = out_frac_q;
	assign res.coordinate_index = out_idx_q;
	assign res.last_in_path     = out_last_q;

endmodule
